// File: sv/rhht_pkg.sv
// shared constants, types and codes of the robin hood hash table
`timescale 1ns / 1ps
package rhht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int HASH_W      = 48;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int SIZE_W      = 4;
  localparam int FILL_W      = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int MIN_SIZE_LOG2 = 4;

  typedef enum logic [1:0] {
    REQ_PUT    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] SIZE_LOG2_RST  = SIZE_W'(10);
  localparam logic [FILL_W-1:0] FILL_LIMIT_RST = FILL_W'(768);

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   probe;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/rhht_ifs.sv
// request, response and configuration channel interfaces
`timescale 1ns / 1ps
interface rhht_req_if import rhht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [HASH_W-1:0]  key_hash;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  modport source (output valid, req_type, key_hash, key, value, input ready);
  modport sink (input valid, req_type, key_hash, key, value, output ready);
endinterface

interface rhht_rsp_if import rhht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [VALUE_W-1:0] value_out;
  logic [CNT_W-1:0]   entry_count;
  modport source (output valid, status, value_out, entry_count, input ready);
  modport sink (input valid, status, value_out, entry_count, output ready);
endinterface

interface rhht_cfg_if import rhht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/robin_hood_hash_table_unit.sv
// robin hood hash table: one slot probed or shifted per cycle out of one ram, while the response channel is not stalled
// steps: probe from the home slot; a put miss walks again from home to insert, a delete shifts followers back
// one request at a time: a new request is taken only in the idle state, once the last one is done
// clear: sweeps every slot of the ram; same sweep runs after reset, no request taken meanwhile
// reset: size_log2 10, fill_limit 768, count 0, response channel empty
`timescale 1ns / 1ps
module robin_hood_hash_table_unit import rhht_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  rhht_req_if.sink   req_i,
  rhht_rsp_if.source rsp_o,
  rhht_cfg_if.sink   cfg_i
);
  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_FIND, S_INS, S_DEL, S_ZAP
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [CNT_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]   cd_q, cd_d;
  logic [1:0]         type_q, type_d;
  logic [HASH_W-1:0]  hash_q, hash_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic               clr_rsp_q, clr_rsp_d;
  logic [CNT_W-1:0]   live_q, live_d;
  logic [SIZE_W-1:0]  size_log2_q;
  logic [FILL_W-1:0]  fill_q;

  logic               rsp_valid_q, rsp_valid_d;
  logic [2:0]         rsp_status_q, rsp_status_d;
  logic [VALUE_W-1:0] rsp_value_q, rsp_value_d;
  logic [CNT_W-1:0]   rsp_count_q, rsp_count_d;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata, rd;
  logic [ENTRY_W-1:0] rd_raw;

  logic [SIZE_W-1:0]  sz;
  logic [CNT_W-1:0]   n_full;
  logic [IDX_W-1:0]   mask;
  logic               last_step, hit, hold;
  logic               fin;
  status_e            fin_st;
  logic [VALUE_W-1:0] fin_val;
  entry_t             cand;

  always_comb begin
    if (size_log2_q < SIZE_W'(MIN_SIZE_LOG2)) begin
      sz = SIZE_W'(MIN_SIZE_LOG2);
    end else if (size_log2_q > SIZE_W'(IDX_W)) begin
      sz = SIZE_W'(IDX_W);
    end else begin
      sz = size_log2_q;
    end
  end

  assign n_full    = CNT_W'(1) << sz;
  assign mask      = IDX_W'(n_full - CNT_W'(1));
  assign last_step = (step_q == n_full - CNT_W'(1));
  assign rd        = entry_t'(rd_raw);
  assign hit       = (rd.probe != '0) && (rd.hash == hash_q) && (rd.key == key_q);
  assign hold      = rsp_valid_q && !rsp_o.ready;
  assign cand      = '{hash: hash_q, key: key_q, value: val_q, probe: cd_q};

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  rhht_ram #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_d),
    .rdata_o (rd_raw)
  );

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    step_d    = step_q;
    cd_d      = cd_q;
    type_d    = type_q;
    hash_d    = hash_q;
    key_d     = key_q;
    val_d     = val_q;
    clr_rsp_d = clr_rsp_q;
    live_d    = live_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    fin       = 1'b0;
    fin_st    = ST_NOT_FOUND;
    fin_val   = '0;

    if (state_q == S_IDLE || !hold) begin
      case (state_q)
        S_CLR: begin
          mem_we = 1'b1;
          addr_d = addr_q + IDX_W'(1);
          if (addr_q == IDX_W'(TABLE_DEPTH - 1)) begin
            live_d  = '0;
            state_d = S_IDLE;
            if (clr_rsp_q) begin
              fin    = 1'b1;
              fin_st = ST_CLEARED;
            end
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            type_d = req_i.req_type;
            hash_d = req_i.key_hash;
            key_d  = req_i.key;
            val_d  = req_i.value;
            step_d = '0;
            if (req_type_e'(req_i.req_type) == REQ_CLEAR) begin
              addr_d    = '0;
              clr_rsp_d = 1'b1;
              state_d   = S_CLR;
            end else begin
              addr_d  = req_i.key_hash[IDX_W-1:0] & mask;
              state_d = S_FIND;
            end
          end
        end
        S_FIND: begin
          if (rd.probe != '0 && !hit && !last_step) begin
            addr_d = (addr_q + IDX_W'(1)) & mask;
            step_d = step_q + CNT_W'(1);
          end else if (hit) begin
            case (req_type_e'(type_q))
              REQ_PUT: begin
                mem_we          = 1'b1;
                mem_wdata       = rd;
                mem_wdata.value = val_q;
                fin             = 1'b1;
                fin_st          = ST_REPLACED;
                fin_val         = rd.value;
              end
              REQ_DELETE: begin
                val_d   = rd.value;
                addr_d  = (addr_q + IDX_W'(1)) & mask;
                step_d  = CNT_W'(1);
                state_d = S_DEL;
              end
              default: begin
                fin     = 1'b1;
                fin_st  = ST_FOUND;
                fin_val = rd.value;
              end
            endcase
          end else if (req_type_e'(type_q) == REQ_PUT) begin
            // miss on a put: refuse or walk again from home to place it
            if (live_q >= CNT_W'(fill_q) || live_q >= n_full - CNT_W'(1) ||
                rd.probe != '0) begin
              fin    = 1'b1;
              fin_st = ST_FULL;
            end else begin
              addr_d  = hash_q[IDX_W-1:0] & mask;
              step_d  = '0;
              cd_d    = CNT_W'(1);
              state_d = S_INS;
            end
          end else begin
            fin    = 1'b1;
            fin_st = ST_NOT_FOUND;
          end
        end
        S_INS: begin
          if (rd.probe == '0) begin
            mem_we    = 1'b1;
            mem_wdata = cand;
            live_d    = live_q + CNT_W'(1);
            fin       = 1'b1;
            fin_st    = ST_INSERTED;
          end else begin
            cd_d = cd_q + CNT_W'(1);
            // richer resident gives up its slot and carries on
            if (rd.probe < cd_q) begin
              mem_we    = 1'b1;
              mem_wdata = cand;
              hash_d    = rd.hash;
              key_d     = rd.key;
              val_d     = rd.value;
              cd_d      = rd.probe + CNT_W'(1);
            end
            if (last_step) begin
              live_d = live_q + CNT_W'(1);
              fin    = 1'b1;
              fin_st = ST_INSERTED;
            end else begin
              addr_d = (addr_q + IDX_W'(1)) & mask;
              step_d = step_q + CNT_W'(1);
            end
          end
        end
        S_DEL: begin
          mem_waddr = (addr_q - IDX_W'(1)) & mask;
          if (rd.probe <= CNT_W'(1)) begin
            mem_we  = 1'b1;
            live_d  = (live_q != '0) ? live_q - CNT_W'(1) : '0;
            fin     = 1'b1;
            fin_st  = ST_DELETED;
            fin_val = val_q;
          end else begin
            mem_we          = 1'b1;
            mem_wdata       = rd;
            mem_wdata.probe = rd.probe - CNT_W'(1);
            if (last_step) begin
              state_d = S_ZAP;
            end else begin
              addr_d = (addr_q + IDX_W'(1)) & mask;
              step_d = step_q + CNT_W'(1);
            end
          end
        end
        S_ZAP: begin
          mem_we  = 1'b1;
          live_d  = (live_q != '0) ? live_q - CNT_W'(1) : '0;
          fin     = 1'b1;
          fin_st  = ST_DELETED;
          fin_val = val_q;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end

    if (fin) begin
      state_d   = S_IDLE;
      clr_rsp_d = 1'b0;
    end

    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_value_d  = rsp_value_q;
    rsp_count_d  = rsp_count_q;
    if (fin) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = fin_st;
      rsp_value_d  = fin_val;
      rsp_count_d  = live_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      addr_q      <= '0;
      step_q      <= '0;
      clr_rsp_q   <= 1'b0;
      live_q      <= '0;
      size_log2_q <= SIZE_LOG2_RST;
      fill_q      <= FILL_LIMIT_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      step_q      <= step_d;
      clr_rsp_q   <= clr_rsp_d;
      live_q      <= live_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.index == CFG_SIZE_LOG2) begin
        size_log2_q <= cfg_i.data[SIZE_W-1:0];
      end
      if (cfg_i.valid && cfg_i.index == CFG_FILL_LIMIT) begin
        fill_q <= cfg_i.data[FILL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cd_q         <= cd_d;
    type_q       <= type_d;
    hash_q       <= hash_d;
    key_q        <= key_d;
    val_q        <= val_d;
    rsp_status_q <= rsp_status_d;
    rsp_value_q  <= rsp_value_d;
    rsp_count_q  <= rsp_count_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.value_out   = rsp_value_q;
  assign rsp_o.entry_count = rsp_count_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we)
    else $error("ram written while idle");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin && fin_st == ST_INSERTED |=> live_q == $past(live_q) + CNT_W'(1))
    else $error("insert did not bump the entry count");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && (state_q == S_DEL || state_q == S_INS) && !fin |-> mem_waddr != addr_d)
    else $error("read and write hit the same slot in one cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q < CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
endmodule

// File: sv/rhht_ram.sv
// single write port, single read port ram with registered read data
`timescale 1ns / 1ps
module rhht_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: tb/rhht_ifs_tb_note.sv
// helper types and scoreboard of the hash table testbench
`timescale 1ns / 1ps
package rhht_tb_pkg;
  import rhht_pkg::*;

  typedef struct {
    status_e           status;
    logic [VALUE_W-1:0] value_out;
    logic [CNT_W-1:0]   entry_count;
  } rsp_item_t;

  // predicts responses of the table and holds them in order
  class rhht_scoreboard;
    logic [HASH_W-1:0]  s_hash [TABLE_DEPTH];
    logic [KEY_W-1:0]   s_key  [TABLE_DEPTH];
    logic [VALUE_W-1:0] s_val  [TABLE_DEPTH];
    int unsigned        s_dist [TABLE_DEPTH];
    int unsigned        count;
    int unsigned        size_log2;
    int unsigned        fill_limit;
    rsp_item_t          pending[$];
    int                 errors;

    function new();
      foreach (s_dist[i]) s_dist[i] = 0;
      count = 0;
      size_log2 = 10;
      fill_limit = 768;
      errors = 0;
    endfunction

    function int unsigned buckets();
      int unsigned s;
      s = size_log2 < MIN_SIZE_LOG2 ? MIN_SIZE_LOG2 : size_log2;
      buckets = (1 << s) > TABLE_DEPTH ? TABLE_DEPTH : (1 << s);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_SIZE_LOG2) size_log2 = 32'(d[SIZE_W-1:0]);
      else if (idx == CFG_FILL_LIMIT) fill_limit = 32'(d);
    endfunction

    function bit lookup(logic [HASH_W-1:0] h, logic [KEY_W-1:0] k, int unsigned n,
                        output int unsigned at, output bit hole);
      int unsigned i;
      i = 32'(h & HASH_W'(n - 1));
      hole = 0;
      at = 0;
      for (int st = 0; st < n; st++) begin
        if (s_dist[i] == 0) begin
          hole = 1;
          return 0;
        end
        if (s_hash[i] == h && s_key[i] == k) begin
          at = i;
          return 1;
        end
        i = (i + 1) & (n - 1);
      end
      return 0;
    endfunction

    // note one accepted request
    function void note_request(req_type_e t, logic [HASH_W-1:0] h,
                               logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
      rsp_item_t r;
      int unsigned n, at, cur, nxt, i, cd, td;
      bit hole;
      logic [HASH_W-1:0] ch, th;
      logic [KEY_W-1:0] ck, tk;
      logic [VALUE_W-1:0] cv, tv;
      n = buckets();
      r.value_out = '0;
      case (t)
        REQ_CLEAR: begin
          foreach (s_dist[j]) s_dist[j] = 0;
          count = 0;
          r.status = ST_CLEARED;
        end
        REQ_GET: begin
          if (lookup(h, k, n, at, hole)) begin
            r.value_out = s_val[at];
            r.status = ST_FOUND;
          end else r.status = ST_NOT_FOUND;
        end
        REQ_DELETE: begin
          if (lookup(h, k, n, at, hole)) begin
            r.value_out = s_val[at];
            cur = at;
            for (int st = 1; st < n; st++) begin
              nxt = (cur + 1) & (n - 1);
              if (s_dist[nxt] <= 1) break;
              s_hash[cur] = s_hash[nxt];
              s_key[cur] = s_key[nxt];
              s_val[cur] = s_val[nxt];
              s_dist[cur] = s_dist[nxt] - 1;
              cur = nxt;
            end
            s_dist[cur] = 0;
            if (count > 0) count--;
            r.status = ST_DELETED;
          end else r.status = ST_NOT_FOUND;
        end
        default: begin
          if (lookup(h, k, n, at, hole)) begin
            r.value_out = s_val[at];
            s_val[at] = v;
            r.status = ST_REPLACED;
          end else if (count >= fill_limit || count >= n - 1 || !hole) begin
            r.status = ST_FULL;
          end else begin
            ch = h; ck = k; cv = v; cd = 1;
            i = 32'(h & HASH_W'(n - 1));
            for (int st = 0; st < n; st++) begin
              if (s_dist[i] == 0) begin
                s_hash[i] = ch; s_key[i] = ck; s_val[i] = cv; s_dist[i] = cd;
                break;
              end
              if (s_dist[i] < cd) begin
                th = s_hash[i]; tk = s_key[i]; tv = s_val[i]; td = s_dist[i];
                s_hash[i] = ch; s_key[i] = ck; s_val[i] = cv; s_dist[i] = cd;
                ch = th; ck = tk; cv = tv; cd = td;
              end
              i = (i + 1) & (n - 1);
              cd++;
            end
            count++;
            r.status = ST_INSERTED;
          end
        end
      endcase
      r.entry_count = CNT_W'(count);
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // check one accepted response against the oldest prediction
    task check_response(logic [2:0] st, logic [VALUE_W-1:0] vo,
                        logic [CNT_W-1:0] ec);
      rsp_item_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response status %0d", st));
        return;
      end
      e = pending.pop_front();
      if (st !== e.status)
        report($sformatf("status got %0d want %0d", st, e.status));
      if (vo !== e.value_out)
        report($sformatf("value_out got %h want %h", vo, e.value_out));
      if (ec !== e.entry_count)
        report($sformatf("entry_count got %0d want %0d", ec, e.entry_count));
    endtask
  endclass
endpackage

// File: tb/robin_hood_hash_table_unit_tb.sv
// testbench of the robin hood hash table against an in-line table predictor
`timescale 1ns / 1ps
module robin_hood_hash_table_unit_tb;
  import rhht_pkg::*;
  import rhht_tb_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  always #6 clk_i = ~clk_i;

  rhht_req_if req_if ();
  rhht_rsp_if rsp_if ();
  rhht_cfg_if cfg_if ();

  robin_hood_hash_table_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .cfg_i(cfg_if.sink)
  );

  rhht_scoreboard table_sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_start = 0;
  bit hold_on = 0;
  logic [KEY_W-1:0] key_pool [16];
  logic [HASH_W-1:0] hash_pool [16];

  // long receiver hold-off, counted here once started
  initial begin
    wait (hold_start);
    hold_on = 1;
    repeat (400) @(negedge clk_i);
    hold_on = 0;
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    if (hold_on) rsp_if.ready <= 0;
    else rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i)
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      table_sb.check_response(rsp_if.status, rsp_if.value_out, rsp_if.entry_count);

  task automatic send_req(req_type_e t, logic [HASH_W-1:0] h, logic [KEY_W-1:0] k,
                          logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 0;
      @(negedge clk_i);
    end
    req_if.valid <= 1; req_if.req_type <= t; req_if.key_hash <= h;
    req_if.key <= k; req_if.value <= v;
    do @(posedge clk_i); while (!req_if.ready);
    table_sb.note_request(t, h, k, v);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1; cfg_if.index <= idx; cfg_if.data <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    table_sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_if.valid <= 0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (table_sb.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  // mostly keys from a small pool so gets, replaces and deletes hit
  task automatic random_req();
    int p;
    req_type_e t;
    logic [HASH_W-1:0] h;
    logic [KEY_W-1:0] k;
    p = $urandom_range(15);
    case ($urandom_range(99)) inside
      [0:44]: t = REQ_PUT;
      [45:69]: t = REQ_GET;
      [70:98]: t = REQ_DELETE;
      default: t = REQ_CLEAR;
    endcase
    if ($urandom_range(9) < 8) begin
      k = key_pool[p] ^ $urandom_range(7);
      // tie hash to key so equal keys stay findable
      h = {k, k[15:0]};
    end else begin
      h = HASH_W'({$urandom, $urandom});
      k = $urandom;
    end
    send_req(t, h, k, $urandom);
  endtask

  task automatic random_phase(int cnt);
    for (int j = 0; j < cnt; j++) random_req();
  endtask

  initial begin
    req_if.valid = 0; req_if.req_type = '0; req_if.key_hash = '0;
    req_if.key = '0; req_if.value = '0;
    cfg_if.valid = 0; cfg_if.index = '0; cfg_if.data = '0;
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom;
      hash_pool[i] = HASH_W'({$urandom, $urandom});
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: extremes, collisions, delete shifts, full
    write_reg(CFG_SIZE_LOG2, CFG_DATA_W'(4));
    write_reg(CFG_FILL_LIMIT, CFG_DATA_W'(1023));
    send_req(REQ_CLEAR, '0, '0, '0);
    send_req(REQ_GET, '0, '0, '0);
    send_req(REQ_DELETE, '1, '1, '0);
    for (int j = 0; j < 16; j++)
      send_req(REQ_PUT, (j < 8) ? 48'h0 : {32'hffffffff, 16'hfff0 | j[3:0]},
               KEY_W'(j), 32'hffffffff - VALUE_W'(j));
    send_req(REQ_PUT, 48'h0, 32'd3, '0);
    send_req(REQ_GET, 48'h0, 32'd5, '0);
    send_req(REQ_DELETE, 48'h0, 32'd0, '0);
    send_req(REQ_GET, 48'h0, 32'd7, '0);
    send_req(REQ_GET, '1, '1, '0);
    drain();

    write_reg(CFG_FILL_LIMIT, CFG_DATA_W'(1));
    send_req(REQ_PUT, 48'h1234, 32'h1, 32'h2);
    drain();
    write_reg(CFG_FILL_LIMIT, CFG_DATA_W'(0));
    send_req(REQ_PUT, 48'h1, 32'h99, 32'h2);
    drain();
    write_reg(CFG_SIZE_LOG2, CFG_DATA_W'(15));
    write_reg(CFG_FILL_LIMIT, CFG_DATA_W'(1023));
    send_req(REQ_CLEAR, '0, '0, '0);

    send_idle_pct = 37; recv_idle_pct = 64;
    random_phase(300);
    // long receiver stall while requests keep coming
    hold_start = 1;
    random_phase(40);
    drain();

    write_reg(CFG_SIZE_LOG2, CFG_DATA_W'(4));
    write_reg(CFG_FILL_LIMIT, CFG_DATA_W'(10));
    send_req(REQ_CLEAR, '0, '0, '0);
    send_idle_pct = 64; recv_idle_pct = 37;
    random_phase(400);
    drain();

    write_reg(CFG_SIZE_LOG2, CFG_DATA_W'(6));
    write_reg(CFG_FILL_LIMIT, CFG_DATA_W'(1023));
    send_req(REQ_CLEAR, '0, '0, '0);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(400);
    drain();

    write_reg(CFG_SIZE_LOG2, CFG_DATA_W'(10));
    write_reg(CFG_FILL_LIMIT, CFG_DATA_W'(768));
    random_phase(360);
    drain();
    repeat (1100) @(negedge clk_i);
    if (table_sb.errors == 0 && table_sb.pending.size() == 0)
      $display("[robin_hood_hash_table_unit] OK");
    else
      $display("[robin_hood_hash_table_unit] ERROR");
    $finish;
  end

  initial begin
    #150ms;
    $display("[robin_hood_hash_table_unit] ERROR");
    $finish;
  end
endmodule
